// ----- hdl/clt_pkg.sv -----
// ============================================================================
// clt_pkg
// Shared types, codes and character constants for the command line tokenizer.
// ============================================================================
package clt_pkg;

  // Widths of the character input and of every position field.
  localparam int unsigned CharW = 16;
  localparam int unsigned PosW  = 16;

  // Lexer states.
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_QUOTED  = 3'd1,
    ST_LITERAL = 3'd2,
    ST_DASHES  = 3'd3,
    ST_DASHARG = 3'd4,
    ST_QPARAM  = 3'd5,
    ST_COLON   = 3'd6,
    ST_DROP    = 3'd7
  } lex_state_e;

  // Token kinds as reported in a record.
  localparam logic [2:0] KIND_LITERAL = 3'd0;
  localparam logic [2:0] KIND_QUOTED  = 3'd1;
  localparam logic [2:0] KIND_DASHED  = 3'd2;
  localparam logic [2:0] KIND_DPARAM  = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  // Token kinds as held in the lexer (no end marker needed there).
  localparam logic [1:0] TK_LITERAL = 2'd0;
  localparam logic [1:0] TK_QUOTED  = 2'd1;
  localparam logic [1:0] TK_DASHED  = 2'd2;
  localparam logic [1:0] TK_DPARAM  = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNCLOSED = 2'd1;
  localparam logic [1:0] ERR_DASHQUOT = 2'd2;

  // Character codes.
  localparam logic [CharW-1:0] CH_QUOTE  = 16'h0022;
  localparam logic [CharW-1:0] CH_DASH   = 16'h002D;
  localparam logic [CharW-1:0] CH_COLON  = 16'h003A;
  localparam logic [CharW-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CharW-1:0] CH_SPACE  = 16'h0020;
  localparam logic [CharW-1:0] CH_TAB    = 16'h0009;
  localparam logic [CharW-1:0] CH_LF     = 16'h000A;
  localparam logic [CharW-1:0] CH_CR     = 16'h000D;

  // One result record.
  typedef struct packed {
    logic [2:0]      kind;
    logic [1:0]      error;
    logic [PosW-1:0] token_start;
    logic [PosW-1:0] token_end;
    logic [PosW-1:0] arg_start;
    logic [PosW-1:0] arg_end;
    logic [PosW-1:0] param_start;
    logic [PosW-1:0] param_end;
    logic            final_res;
  } res_t;

endpackage : clt_pkg

// ----- hdl/clt_lexer.sv -----
// ============================================================================
// clt_lexer
// Lexer state and the single-pass decision logic for one character.
// ============================================================================
module clt_lexer (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [clt_pkg::CharW-1:0] char_i,
  input  logic                    last_i,
  output logic                    res_valid_o,
  output clt_pkg::res_t           res_o
);
  import clt_pkg::*;

  lex_state_e      st_q, st_d;
  logic            par_q, par_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] tb_q, tb_d;
  logic [PosW-1:0] ab_q, ab_d;
  logic [PosW-1:0] af_q, af_d;
  logic [PosW-1:0] pb_q, pb_d;
  logic [1:0]      tk_q, tk_d;

  logic [PosW-1:0] p, n;
  logic            ws, is_q, is_dash, is_colon, is_bs, made;
  res_t            r;

  // Character classes.
  assign is_q     = (char_i == CH_QUOTE);
  assign is_dash  = (char_i == CH_DASH);
  assign is_colon = (char_i == CH_COLON);
  assign is_bs    = (char_i == CH_BSLASH);
  assign ws       = (char_i == CH_SPACE) || (char_i == CH_TAB) ||
                    (char_i == CH_LF) || (char_i == CH_CR);
  assign p        = pos_q;
  assign n        = pos_q + 1'b1;

  // Next state and record for the current character.
  always_comb begin
    st_d  = st_q;
    par_d = par_q;
    tb_d  = tb_q;
    ab_d  = ab_q;
    af_d  = af_q;
    pb_d  = pb_q;
    tk_d  = tk_q;
    pos_d = n;
    made  = 1'b0;
    r     = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (!ws) begin
          tb_d  = p;
          par_d = 1'b0;
          if (is_q) begin
            st_d = ST_QUOTED;
            tk_d = TK_QUOTED;
            ab_d = n;
          end else if (is_dash) begin
            st_d = ST_DASHES;
            tk_d = TK_DASHED;
          end else begin
            st_d = ST_LITERAL;
            tk_d = TK_LITERAL;
            ab_d = p;
          end
        end
      end
      ST_LITERAL: begin
        if (ws) begin
          r    = '{KIND_LITERAL, ERR_NONE, tb_q, p, ab_q, p, p, p, 1'b0};
          made = 1'b1;
          st_d = ST_IDLE;
        end
      end
      ST_QUOTED: begin
        if (is_q && !par_q) begin
          r    = '{KIND_QUOTED, ERR_NONE, tb_q, n, ab_q, p, n, n, 1'b0};
          made = 1'b1;
          st_d = ST_IDLE;
        end
        par_d = is_bs ? ~par_q : 1'b0;
      end
      ST_DASHES: begin
        if (ws) begin
          r    = '{KIND_DASHED, ERR_NONE, tb_q, p, p, p, p, p, 1'b0};
          made = 1'b1;
          st_d = ST_IDLE;
        end else if (is_q) begin
          r    = '{KIND_DASHED, ERR_DASHQUOT, tb_q, n, '0, '0, '0, '0, 1'b0};
          made = 1'b1;
          st_d = ST_DROP;
        end else if (!is_dash) begin
          st_d = ST_DASHARG;
          ab_d = p;
        end
      end
      ST_DASHARG: begin
        if (ws) begin
          r    = '{KIND_DASHED, ERR_NONE, tb_q, p, ab_q, p, p, p, 1'b0};
          made = 1'b1;
          st_d = ST_IDLE;
        end else if (is_colon) begin
          st_d = ST_COLON;
          af_d = p;
        end else if (is_q) begin
          st_d  = ST_QPARAM;
          tk_d  = TK_DPARAM;
          af_d  = p;
          pb_d  = n;
          par_d = 1'b0;
        end
      end
      ST_COLON: begin
        if (is_q) begin
          st_d  = ST_QPARAM;
          tk_d  = TK_DPARAM;
          pb_d  = n;
          par_d = 1'b0;
        end else if (!is_colon) begin
          st_d = ST_DASHARG;
        end
      end
      ST_QPARAM: begin
        if (is_q && !par_q) begin
          r    = '{KIND_DPARAM, ERR_NONE, tb_q, n, ab_q, af_q, pb_q, p, 1'b0};
          made = 1'b1;
          st_d = ST_IDLE;
        end
        par_d = is_bs ? ~par_q : 1'b0;
      end
      ST_DROP: begin
      end
      default: begin
      end
    endcase

    // The last character closes the input with a final record and a restart.
    if (last_i) begin
      if (!made) begin
        unique case (st_d)
          ST_IDLE:
            r = '{KIND_END, ERR_NONE, n, n, n, n, n, n, 1'b0};
          ST_LITERAL, ST_DASHARG, ST_COLON:
            r = '{{1'b0, tk_d}, ERR_NONE, tb_d, n, ab_d, n, n, n, 1'b0};
          ST_DASHES:
            r = '{KIND_DASHED, ERR_NONE, tb_d, n, n, n, n, n, 1'b0};
          ST_QUOTED, ST_QPARAM:
            r = '{{1'b0, tk_d}, ERR_UNCLOSED, tb_d, n, '0, '0, '0, '0, 1'b0};
          default:
            r = '{KIND_END, ERR_DASHQUOT, n, n, n, n, n, n, 1'b0};
        endcase
      end
      r.final_res = 1'b1;
      made  = 1'b1;
      st_d  = ST_IDLE;
      par_d = 1'b0;
      pos_d = '0;
      tb_d  = '0;
      ab_d  = '0;
      af_d  = '0;
      pb_d  = '0;
      tk_d  = TK_LITERAL;
    end
  end

  assign res_valid_o = made;
  assign res_o       = r;

  // Lexer state registers, advanced once per character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      par_q <= 1'b0;
      pos_q <= '0;
      tb_q  <= '0;
      ab_q  <= '0;
      af_q  <= '0;
      pb_q  <= '0;
      tk_q  <= TK_LITERAL;
    end else if (step_i) begin
      st_q  <= st_d;
      par_q <= par_d;
      pos_q <= pos_d;
      tb_q  <= tb_d;
      ab_q  <= ab_d;
      af_q  <= af_d;
      pb_q  <= pb_d;
      tk_q  <= tk_d;
    end
  end

endmodule : clt_lexer

// ----- hdl/clt_out_stage.sv -----
// ============================================================================
// clt_out_stage
// Result register holding one record until the downstream side takes it.
// ============================================================================
module clt_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  clt_pkg::res_t res_i,
  input  logic          ready_i,
  output logic          free_o,
  output logic          valid_o,
  output clt_pkg::res_t res_o
);
  import clt_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // The register can take a new record when empty or when emptied this cycle.
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !ready_i);

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Record payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule : clt_out_stage

// ----- hdl/command_line_tokenizer.sv -----
// ============================================================================
// command_line_tokenizer
// Splits a stream of wide characters into token records with positions.
// ============================================================================
// An accepted character waits in the input register; the lexer logic then
// loads its record into the result register. Throughput: one character per
// cycle while the result register is free; the lexer state is the only loop.
// Reset: asynchronous, active low; clears lexer state, position and the valid
// flags of both stages. After each last character the lexer restarts at zero.
module command_line_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input characters.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] character
  input  logic        s_axis_tlast,
  // Result records.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // token_start, token_end, arg_start,
                                      // arg_end, param_start, param_end
  output logic [4:0]  m_axis_tuser,   // [2:0] kind, [4:3] error
  output logic        m_axis_tlast    // final_res
);
  import clt_pkg::*;

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;
  logic             out_free, step, res_valid;
  res_t             res, out_res;

  // A held character moves on when the result register can take its record.
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  clt_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_i      (in_char_q),
    .last_i      (in_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  clt_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  // Pack the record onto the output request.
  assign m_axis_tdata = {out_res.param_end, out_res.param_start, out_res.arg_end,
                         out_res.arg_start, out_res.token_end, out_res.token_start};
  assign m_axis_tuser = {out_res.error, out_res.kind};
  assign m_axis_tlast = out_res.final_res;

endmodule : command_line_tokenizer

// ----- hdl/clt_checker.sv -----
// ============================================================================
// clt_checker
// Port-level checks on the records leaving the command line tokenizer.
// ============================================================================
module clt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import clt_pkg::*;

  // Only defined kinds leave the block.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[2:0] == KIND_LITERAL || m_axis_tuser[2:0] == KIND_QUOTED ||
                       m_axis_tuser[2:0] == KIND_DASHED || m_axis_tuser[2:0] == KIND_DPARAM ||
                       m_axis_tuser[2:0] == KIND_END))
    else $error("clt: undefined kind on output");

  // An unclosed quote can only be reported when the input closes.
  a_unclosed_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[4:3] == ERR_UNCLOSED) |-> m_axis_tlast)
    else $error("clt: unclosed-quote record without final flag");

  // The end marker only ever closes the input.
  a_end_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2:0] == KIND_END) |-> m_axis_tlast)
    else $error("clt: end marker without final flag");

  // A quote after dashes is reported on a dashed token unless the input closes.
  a_dashquote_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[4:3] == ERR_DASHQUOT && !m_axis_tlast)
      |-> (m_axis_tuser[2:0] == KIND_DASHED))
    else $error("clt: dash-quote error on wrong kind");

  // A stalled record holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("clt: stalled record changed");

endmodule : clt_checker

bind command_line_tokenizer clt_checker u_clt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/tb_command_line_tokenizer.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_command_line_tokenizer
// Self-checking bench for the command line tokenizer. Command lines are fed
// one character per request. A behavioural tokenizer in the bench predicts
// every token record, and each record taken from the block is compared
// with the oldest prediction, field by field. Directed lines cover the
// token kinds and error records. Random lines then run under several source
// and sink idling phases.
// ============================================================================
module tb_command_line_tokenizer;
  import clt_pkg::*;

  // Two register stages between an accepted character and its record.
  localparam int unsigned LatencyCycles = 2;
  localparam int unsigned SettleCycles  = LatencyCycles + 4;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [15:0] character
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;          // token_start, token_end, arg_start,
                                      // arg_end, param_start, param_end
  logic [4:0]  m_axis_tuser;          // [2:0] kind, [4:3] error
  logic        m_axis_tlast;          // final_res

  command_line_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Bench state: predicted records, the line being sent and idling rates.
  res_t        expected_records[$];
  logic [15:0] line_chars[$];
  int unsigned failures       = 0;
  int unsigned chars_sent     = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  // Shadow lexer state of the predictor.
  lex_state_e  lx_state;
  bit          bs_odd;
  logic [15:0] char_pos;
  logic [15:0] tok_start_q;
  logic [15:0] arg_start_q;
  logic [15:0] arg_stop_q;
  logic [15:0] par_start_q;
  logic [1:0]  tok_kind_q;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run-time limit, well above the slowest legal run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic bit is_blank(input logic [15:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic res_t make_rec(input logic [2:0] k, input logic [1:0] e,
                                    input logic [15:0] t0, t1, a0, a1, p0, p1);
    res_t r;
    r.kind        = k;
    r.error       = e;
    r.token_start = t0;
    r.token_end   = t1;
    r.arg_start   = a0;
    r.arg_end     = a1;
    r.param_start = p0;
    r.param_end   = p1;
    r.final_res   = 1'b0;
    return r;
  endfunction

  // Appends one character to the line being built.
  task automatic add_char(input logic [15:0] c);
    line_chars.insert(line_chars.size(), c);
  endtask

  task automatic restart_lexer();
    lx_state    = ST_IDLE;
    bs_odd      = 1'b0;
    char_pos    = '0;
    tok_start_q = '0;
    arg_start_q = '0;
    arg_stop_q  = '0;
    par_start_q = '0;
    tok_kind_q  = TK_LITERAL;
  endtask

  // Advances the shadow lexer by one character and queues any record it
  // gives. Positions wrap naturally at the 16-bit width.
  task automatic tokenize_char(input logic [15:0] ch, input bit is_last);
    res_t        rec;
    bit          made;
    bit          ws;
    logic [15:0] p;
    logic [15:0] n;
    p    = char_pos;
    n    = char_pos + 16'd1;
    ws   = is_blank(ch);
    made = 1'b0;
    rec  = '0;
    case (lx_state)
      ST_IDLE: begin
        if (!ws) begin
          tok_start_q = p;
          bs_odd      = 1'b0;
          if (ch == CH_QUOTE) begin
            lx_state    = ST_QUOTED;
            tok_kind_q  = TK_QUOTED;
            arg_start_q = n;
          end else if (ch == CH_DASH) begin
            lx_state   = ST_DASHES;
            tok_kind_q = TK_DASHED;
          end else begin
            lx_state    = ST_LITERAL;
            tok_kind_q  = TK_LITERAL;
            arg_start_q = p;
          end
        end
      end
      ST_LITERAL: begin
        if (ws) begin
          rec      = make_rec(KIND_LITERAL, ERR_NONE, tok_start_q, p, arg_start_q, p, p, p);
          made     = 1'b1;
          lx_state = ST_IDLE;
        end
      end
      ST_QUOTED: begin
        if (ch == CH_QUOTE && !bs_odd) begin
          rec      = make_rec(KIND_QUOTED, ERR_NONE, tok_start_q, n, arg_start_q, p, n, n);
          made     = 1'b1;
          lx_state = ST_IDLE;
        end
        bs_odd = (ch == CH_BSLASH) ? ~bs_odd : 1'b0;
      end
      ST_DASHES: begin
        if (ws) begin
          rec      = make_rec(KIND_DASHED, ERR_NONE, tok_start_q, p, p, p, p, p);
          made     = 1'b1;
          lx_state = ST_IDLE;
        end else if (ch == CH_QUOTE) begin
          rec      = make_rec(KIND_DASHED, ERR_DASHQUOT, tok_start_q, n, '0, '0, '0, '0);
          made     = 1'b1;
          lx_state = ST_DROP;
        end else if (ch != CH_DASH) begin
          lx_state    = ST_DASHARG;
          arg_start_q = p;
        end
      end
      ST_DASHARG: begin
        if (ws) begin
          rec      = make_rec(KIND_DASHED, ERR_NONE, tok_start_q, p, arg_start_q, p, p, p);
          made     = 1'b1;
          lx_state = ST_IDLE;
        end else if (ch == CH_COLON) begin
          lx_state   = ST_COLON;
          arg_stop_q = p;
        end else if (ch == CH_QUOTE) begin
          lx_state    = ST_QPARAM;
          tok_kind_q  = TK_DPARAM;
          arg_stop_q  = p;
          par_start_q = n;
          bs_odd      = 1'b0;
        end
      end
      ST_COLON: begin
        // Whitespace here does not end the token; it falls back to the
        // argument like any other character.
        if (ch == CH_QUOTE) begin
          lx_state    = ST_QPARAM;
          tok_kind_q  = TK_DPARAM;
          par_start_q = n;
          bs_odd      = 1'b0;
        end else if (ch != CH_COLON) begin
          lx_state = ST_DASHARG;
        end
      end
      ST_QPARAM: begin
        if (ch == CH_QUOTE && !bs_odd) begin
          rec      = make_rec(KIND_DPARAM, ERR_NONE, tok_start_q, n, arg_start_q, arg_stop_q,
                              par_start_q, p);
          made     = 1'b1;
          lx_state = ST_IDLE;
        end
        bs_odd = (ch == CH_BSLASH) ? ~bs_odd : 1'b0;
      end
      default: begin
        // Characters after a quote that follows the dashes are dropped.
      end
    endcase

    if (!is_last) begin
      char_pos = n;
      if (made) expected_records.insert(expected_records.size(), rec);
    end else begin
      // The last character always closes the input with one final record.
      if (!made) begin
        case (lx_state)
          ST_IDLE:
            rec = make_rec(KIND_END, ERR_NONE, n, n, n, n, n, n);
          ST_LITERAL, ST_DASHARG, ST_COLON:
            rec = make_rec({1'b0, tok_kind_q}, ERR_NONE, tok_start_q, n, arg_start_q, n, n, n);
          ST_DASHES:
            rec = make_rec(KIND_DASHED, ERR_NONE, tok_start_q, n, n, n, n, n);
          ST_QUOTED, ST_QPARAM:
            rec = make_rec({1'b0, tok_kind_q}, ERR_UNCLOSED, tok_start_q, n, '0, '0, '0, '0);
          default:
            rec = make_rec(KIND_END, ERR_DASHQUOT, n, n, n, n, n, n);
        endcase
      end
      rec.final_res = 1'b1;
      expected_records.insert(expected_records.size(), rec);
      restart_lexer();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Compares one record taken from the block with the oldest prediction.
  task automatic check_record();
    res_t want;
    if (expected_records.size() == 0) begin
      $error("record with no prediction waiting: tuser %h tdata %h", m_axis_tuser, m_axis_tdata);
      failures++;
    end else begin
      want = expected_records.pop_front();
      check_field("kind",        want.kind,        m_axis_tuser[2:0]);
      check_field("error",       want.error,       m_axis_tuser[4:3]);
      check_field("token_start", want.token_start, m_axis_tdata[15:0]);
      check_field("token_end",   want.token_end,   m_axis_tdata[31:16]);
      check_field("arg_start",   want.arg_start,   m_axis_tdata[47:32]);
      check_field("arg_end",     want.arg_end,     m_axis_tdata[63:48]);
      check_field("param_start", want.param_start, m_axis_tdata[79:64]);
      check_field("param_end",   want.param_end,   m_axis_tdata[95:80]);
      check_field("final_res",   want.final_res,   m_axis_tlast);
    end
  endtask

  // Monitor: records are checked before the accepted character is
  // predicted, so the order within one edge is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_record();
      if (s_axis_tvalid && s_axis_tready) tokenize_char(s_axis_tdata, s_axis_tlast);
    end
  end

  // Sink: random stalls at the rate of the current phase.
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Drives one character request and returns once it has been accepted.
  task automatic push_char(input logic [15:0] ch, input bit is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ch;
    s_axis_tlast  = is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    chars_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_chars.size(); i++) begin
      push_char(line_chars[i], i == line_chars.size() - 1);
    end
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_text(input string s);
    line_chars.delete();
    for (int i = 0; i < s.len(); i++) add_char({8'h00, s[i]});
    send_line();
  endtask

  // Holds the source until every predicted record has come out.
  task automatic wait_for_records();
    while (expected_records.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_blank();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Any code that has no meaning to the lexer, often printable ASCII.
  function automatic logic [15:0] rand_plain();
    logic [15:0] c;
    c = $urandom_range(1) ? 16'($urandom_range(33, 126)) : 16'($urandom_range(65535));
    while (is_blank(c) || c == CH_QUOTE || c == CH_DASH || c == CH_COLON || c == CH_BSLASH)
      c = 16'($urandom_range(65535));
    return c;
  endfunction

  function automatic logic [15:0] rand_inner();
    case ($urandom_range(5))
      0:       return CH_QUOTE;
      1:       return CH_DASH;
      2:       return CH_COLON;
      3:       return CH_BSLASH;
      default: return rand_plain();
    endcase
  endfunction

  // Body of a quoted token or parameter with escapes, normally closed.
  task automatic add_quoted_body(input bit may_stay_open);
    repeat ($urandom_range(4)) begin
      case ($urandom_range(4))
        0: add_char(rand_blank());
        1: add_char(rand_plain());
        2: begin
          add_char(CH_BSLASH);
          add_char(CH_BSLASH);
        end
        3: begin
          add_char(CH_BSLASH);
          add_char(CH_QUOTE);
        end
        default: begin
          add_char(CH_BSLASH);
          add_char(rand_plain());
        end
      endcase
    end
    if (!may_stay_open || $urandom_range(9) != 0) add_char(CH_QUOTE);
  endtask

  // Builds a line of mostly well-formed tokens with random content. With
  // breaks allowed it also holds noise, unclosed quotes and quotes right
  // after the dashes.
  task automatic build_line(input int min_tokens, input int min_len, input bit allow_breaks);
    int n_tok;
    int choice;
    int n_arg;
    bit with_param;
    line_chars.delete();
    n_tok = 0;
    while (n_tok < min_tokens || line_chars.size() < min_len) begin
      repeat ($urandom_range(2)) add_char(rand_blank());
      choice = $urandom_range(9);
      if (!allow_breaks && choice >= 8) choice = 0;
      case (choice)
        0, 1, 2: begin
          add_char(rand_plain());
          repeat ($urandom_range(4)) add_char(rand_inner());
        end
        3, 4: begin
          add_char(CH_QUOTE);
          add_quoted_body(allow_breaks);
        end
        5, 6, 7: begin
          repeat ($urandom_range(1, 3)) add_char(CH_DASH);
          with_param = $urandom_range(1);
          n_arg      = $urandom_range(3);
          if (with_param && !allow_breaks && n_arg == 0) n_arg = 1;
          repeat (n_arg) add_char(rand_plain());
          if (with_param) begin
            repeat ($urandom_range(2)) add_char(CH_COLON);
            if ($urandom_range(3) == 0) add_char(rand_blank());
            add_char(CH_QUOTE);
            add_quoted_body(allow_breaks);
          end
        end
        8: begin
          repeat ($urandom_range(1, 2)) add_char(CH_DASH);
          add_char(CH_QUOTE);
        end
        default: begin
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(2))
              0:       add_char(rand_inner());
              1:       add_char(rand_blank());
              default: add_char(16'($urandom_range(65535)));
            endcase
          end
        end
      endcase
      add_char(rand_blank());
      n_tok++;
    end
    // Often leave the last token open so that the end of input closes it.
    if ($urandom_range(1)) line_chars.delete(line_chars.size() - 1);
  endtask

  // Dashed tokens and a colon parameter closed by the last character.
  task automatic test_dashed_tokens();
    send_text(" -- -a:\"p\"");
  endtask

  // Escaped quote, whitespace after a colon and an unclosed parameter.
  task automatic test_quoting();
    send_text("\"\\\"\" -a: \"q");
  endtask

  // Quote after the dashes, then dropped characters up to the last one.
  task automatic test_dash_quote_error();
    send_text("-\"x");
  endtask

  // Extreme character codes, the last one leaving a literal open.
  task automatic test_extreme_chars();
    line_chars.delete();
    add_char(CH_DASH);
    add_char(CH_TAB);
    add_char(16'hFFFF);
    add_char(16'h0000);
    send_line();
  endtask

  // A line of whitespace only ends with the end marker.
  task automatic test_blank_line();
    line_chars.delete();
    add_char(CH_CR);
    add_char(CH_LF);
    send_line();
  endtask

  task automatic run_random_phase(input int unsigned src_pct, input int unsigned sink_pct,
                                  input int unsigned target);
    int unsigned start;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start          = chars_sent;
    while (chars_sent - start < target) begin
      build_line($urandom_range(1, 5), 0, 1'b1);
      send_line();
      // Now and then the source waits for every outstanding record.
      if ($urandom_range(9) == 0) wait_for_records();
    end
    wait_for_records();
  endtask

  task automatic test_random_lines();
    run_random_phase(0, 0, 430);
    run_random_phase(86, 0, 430);
    run_random_phase(0, 86, 430);
    run_random_phase(32, 32, 430);
  endtask

  // Sequence of tests.
  initial begin
    restart_lexer();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_dashed_tokens();
    test_quoting();
    test_dash_quote_error();
    test_extreme_chars();
    test_blank_line();
    wait_for_records();
    test_random_lines();

    wait_for_records();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
